[hdl/cpe_pkg.sv]
// Shared constants, codes and types of the CHROM pulse extractor.
`timescale 1ns / 1ps
`default_nettype none
package cpe_pkg;

	localparam int WINDOW_FRAMES = 60;
	localparam int MIN_HISTORY   = 30;
	localparam int WARMUP_FRAMES = 15;

	localparam int LEVEL_W  = 16;
	localparam int HIST_W   = 12;
	localparam int WEIGHT_W = 16;
	localparam int RUN_W    = 24;
	localparam int ACC_W    = WEIGHT_W + 1 + RUN_W;
	localparam int NORM_W   = 20;
	localparam int DREM_W   = RUN_W + 1;
	localparam int DIV_BITS_PER_CYCLE = 4;
	localparam int DIV_CYCLES = NORM_W / DIV_BITS_PER_CYCLE;
	localparam int WARM_W   = 4;
	localparam int SLOT_W   = 6;
	localparam int SLOTS    = 1 << SLOT_W;
	localparam int ENTRY_W  = 3 * LEVEL_W;
	localparam int XY_W     = 24;
	localparam int SQ_W     = 2 * XY_W;
	localparam int WIN_W    = $clog2(WINDOW_FRAMES + 1);
	localparam int SUM_W    = XY_W + WIN_W;
	localparam int QSUM_W   = SQ_W + WIN_W;
	localparam int SS_W     = 64;
	localparam int RATIO_W  = 48;
	localparam int RATIO_FRAC = 34;
	localparam int RSH      = RATIO_W - RATIO_FRAC;
	localparam int RATIO_CYCLES = RATIO_W;
	localparam int SQRT_CYCLES  = RATIO_W / 2;
	localparam int SCALE_W  = 24;
	localparam int CNT_W    = $clog2(RATIO_CYCLES);
	localparam int PULSE_W  = 32;
	localparam int PULSE_SH = 17;
	localparam int PROD_W   = SCALE_W + 1 + XY_W;
	localparam int DIFF_W   = PROD_W + 1;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 3;

	localparam logic [NORM_W-1:0]  NORM_MAX  = {NORM_W{1'b1}};
	localparam logic [RUN_W-1:0]   ONE_Q16   = RUN_W'(32'h10000);
	localparam logic [SCALE_W-1:0] SCALE_MAX = {SCALE_W{1'b1}};
	localparam logic [WARM_W-1:0]  WARM_MAX  = {WARM_W{1'b1}};

	localparam logic [HIST_W-1:0]   HIST_RESET   = HIST_W'(1800);
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(62259);

	localparam logic [1:0] ACT_FRAME = 2'd0;
	localparam logic [1:0] ACT_EMPTY = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	localparam logic REG_HISTORY = 1'b0;
	localparam logic REG_WEIGHT  = 1'b1;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_LATCH,
		OP_CLEAR,
		OP_ZERO,
		OP_WARM,
		OP_SMOOTH_A,
		OP_SMOOTH_B,
		OP_DIV_CUR,
		OP_DIV_MEM,
		OP_DIV_STEP,
		OP_CUR_XY,
		OP_WIN_INIT,
		OP_MEM_RD,
		OP_WIN_XY,
		OP_WIN_ACC,
		OP_SS_MUL,
		OP_SS_SUB,
		OP_SCALE_SAT,
		OP_RATIO_INIT,
		OP_RATIO_STEP,
		OP_SQRT_INIT,
		OP_SQRT_STEP,
		OP_SQRT_DONE,
		OP_PULSE_MUL,
		OP_PULSE_OUT,
		OP_OUT_LOAD
	} cpe_op_t;

	typedef struct packed {
		logic [1:0] action;
		logic       warm_ok;
		logic       hist_ok;
		logic       win_last;
		logic       ssy_pos;
		logic       ratio_sat;
	} cpe_stat_t;

	typedef struct packed {
		logic [HIST_W-1:0]   history_limit;
		logic [WEIGHT_W-1:0] smoothing_weight;
	} cpe_cfg_t;

endpackage
`default_nettype wire

[hdl/cpe_in_if.sv]
// Input word channel: frame action and region mean levels.
`timescale 1ns / 1ps
`default_nettype none
interface cpe_in_if import cpe_pkg::*;;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic [LEVEL_W-1:0] red_level;
	logic [LEVEL_W-1:0] green_level;
	logic [LEVEL_W-1:0] blue_level;

	modport source (output valid, action, red_level, green_level, blue_level, input ready);
	modport sink (input valid, action, red_level, green_level, blue_level, output ready);
endinterface
`default_nettype wire

[hdl/cpe_out_if.sv]
// Output word channel: pulse sample and applied scale.
`timescale 1ns / 1ps
`default_nettype none
interface cpe_out_if import cpe_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic signed [PULSE_W-1:0] pulse_value;
	logic                      pulse_valid;
	logic [SCALE_W-1:0]        scale_used;

	modport source (output valid, pulse_value, pulse_valid, scale_used, input ready);
	modport sink (input valid, pulse_value, pulse_valid, scale_used, output ready);
endinterface
`default_nettype wire

[hdl/cpe_regs.sv]
// APB configuration registers: history limit and smoothing weight.
`timescale 1ns / 1ps
`default_nettype none
module cpe_regs import cpe_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cpe_cfg_t               cfg
);

	logic [HIST_W-1:0]   history_limit_q;
	logic [WEIGHT_W-1:0] smoothing_weight_q;
	logic                wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			history_limit_q    <= HIST_RESET;
			smoothing_weight_q <= WEIGHT_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_HISTORY: history_limit_q    <= pwdata[HIST_W-1:0];
				REG_WEIGHT:  smoothing_weight_q <= pwdata[WEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_HISTORY: prdata = DATA_W'(history_limit_q);
			REG_WEIGHT:  prdata = DATA_W'(smoothing_weight_q);
			default:     prdata = '0;
		endcase
	end

	assign cfg.history_limit    = history_limit_q;
	assign cfg.smoothing_weight = smoothing_weight_q;

endmodule
`default_nettype wire

[hdl/cpe_ctrl.sv]
// Controller: sequences one frame through the datapath and owns the handshakes.
`timescale 1ns / 1ps
`default_nettype none
module cpe_ctrl import cpe_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	input  wire cpe_stat_t stat,
	output cpe_op_t        op
);

	typedef enum logic [22:0] {
		S_IDLE      = 23'h000001,
		S_CHECK     = 23'h000002,
		S_SMOOTH_A  = 23'h000004,
		S_SMOOTH_B  = 23'h000008,
		S_DIV_LOAD  = 23'h000010,
		S_DIV_CUR   = 23'h000020,
		S_CUR_XY    = 23'h000040,
		S_WIN_INIT  = 23'h000080,
		S_WIN_RD    = 23'h000100,
		S_WIN_LOAD  = 23'h000200,
		S_WIN_DIV   = 23'h000400,
		S_WIN_XY    = 23'h000800,
		S_WIN_ACC   = 23'h001000,
		S_SS_MUL    = 23'h002000,
		S_SS_SUB    = 23'h004000,
		S_RCHK      = 23'h008000,
		S_RATIO     = 23'h010000,
		S_SQRT_INIT = 23'h020000,
		S_SQRT      = 23'h040000,
		S_SQRT_DONE = 23'h080000,
		S_PULSE_MUL = 23'h100000,
		S_PULSE_OUT = 23'h200000,
		S_DONE      = 23'h400000
	} cpe_state_t;

	cpe_state_t       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             out_valid_q;
	logic             out_load;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		op      = OP_NOP;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op      = OP_LATCH;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.action == ACT_CLEAR) begin
					op      = OP_CLEAR;
					state_d = S_DONE;
				end else if (stat.action != ACT_FRAME) begin
					op      = OP_ZERO;
					state_d = S_DONE;
				end else begin
					op      = OP_WARM;
					state_d = stat.warm_ok ? S_SMOOTH_A : S_DONE;
				end
			end
			S_SMOOTH_A: begin
				op      = OP_SMOOTH_A;
				state_d = S_SMOOTH_B;
			end
			S_SMOOTH_B: begin
				op      = OP_SMOOTH_B;
				state_d = S_DIV_LOAD;
			end
			S_DIV_LOAD: begin
				op      = OP_DIV_CUR;
				state_d = S_DIV_CUR;
			end
			S_DIV_CUR: begin
				op = OP_DIV_STEP;
				if (cnt_q == CNT_W'(DIV_CYCLES - 1)) begin
					cnt_d   = '0;
					state_d = S_CUR_XY;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_CUR_XY: begin
				op      = OP_CUR_XY;
				state_d = stat.hist_ok ? S_WIN_INIT : S_PULSE_MUL;
			end
			S_WIN_INIT: begin
				op      = OP_WIN_INIT;
				state_d = S_WIN_RD;
			end
			S_WIN_RD: begin
				op      = OP_MEM_RD;
				state_d = S_WIN_LOAD;
			end
			S_WIN_LOAD: begin
				op      = OP_DIV_MEM;
				state_d = S_WIN_DIV;
			end
			S_WIN_DIV: begin
				op = OP_DIV_STEP;
				if (cnt_q == CNT_W'(DIV_CYCLES - 1)) begin
					cnt_d   = '0;
					state_d = S_WIN_XY;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_WIN_XY: begin
				op      = OP_WIN_XY;
				state_d = S_WIN_ACC;
			end
			S_WIN_ACC: begin
				op      = OP_WIN_ACC;
				state_d = stat.win_last ? S_SS_MUL : S_WIN_RD;
			end
			S_SS_MUL: begin
				op      = OP_SS_MUL;
				state_d = S_SS_SUB;
			end
			S_SS_SUB: begin
				op      = OP_SS_SUB;
				state_d = S_RCHK;
			end
			S_RCHK: begin
				// zero Y spread keeps the unit scale set with the current sample
				if (!stat.ssy_pos) begin
					state_d = S_PULSE_MUL;
				end else if (stat.ratio_sat) begin
					op      = OP_SCALE_SAT;
					state_d = S_PULSE_MUL;
				end else begin
					op      = OP_RATIO_INIT;
					state_d = S_RATIO;
				end
			end
			S_RATIO: begin
				op = OP_RATIO_STEP;
				if (cnt_q == CNT_W'(RATIO_CYCLES - 1)) begin
					cnt_d   = '0;
					state_d = S_SQRT_INIT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_SQRT_INIT: begin
				op      = OP_SQRT_INIT;
				state_d = S_SQRT;
			end
			S_SQRT: begin
				op = OP_SQRT_STEP;
				if (cnt_q == CNT_W'(SQRT_CYCLES - 1)) begin
					cnt_d   = '0;
					state_d = S_SQRT_DONE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_SQRT_DONE: begin
				op      = OP_SQRT_DONE;
				state_d = S_PULSE_MUL;
			end
			S_PULSE_MUL: begin
				op      = OP_PULSE_MUL;
				state_d = S_PULSE_OUT;
			end
			S_PULSE_OUT: begin
				op      = OP_PULSE_OUT;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_load) begin
					op      = OP_OUT_LOAD;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
				cnt_d   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

[hdl/cpe_dp.sv]
// Datapath: running means, norm dividers, window sums, ratio divider, root, pulse.
`timescale 1ns / 1ps
`default_nettype none
module cpe_dp import cpe_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cpe_op_t            op,
	input  wire cpe_cfg_t           cfg,
	input  wire logic [1:0]         in_action,
	input  wire logic [LEVEL_W-1:0] in_red,
	input  wire logic [LEVEL_W-1:0] in_green,
	input  wire logic [LEVEL_W-1:0] in_blue,
	output cpe_stat_t               stat,
	output logic signed [PULSE_W-1:0] pulse_value,
	output logic                    pulse_valid,
	output logic [SCALE_W-1:0]      scale_used
);

	localparam logic [RATIO_W-1:0] SQB_INIT = RATIO_W'(1) << (RATIO_W - 2);
	localparam logic signed [DIFF_W-1:0] P_MAX = DIFF_W'(32'h7FFFFFFF);
	localparam logic signed [DIFF_W-1:0] P_MIN = -P_MAX - DIFF_W'(1);

	// frame state
	logic [WARM_W-1:0]  warmup_q;
	logic [HIST_W-1:0]  stored_q;
	logic [RUN_W-1:0]   run_q [3];
	logic [SLOT_W-1:0]  slot_q;

	// captured word
	logic [1:0]         action_q;
	logic [LEVEL_W-1:0] lvl_q [3];

	// working registers
	logic [ACC_W-1:0]   acc_q [3];
	logic [DREM_W-1:0]  drem_q [3];
	logic [NORM_W-1:0]  dquo_q [3];
	logic               dsat_q [3];
	logic signed [XY_W-1:0] x_q, y2_q, ex_q, ey_q;
	logic [WIN_W-1:0]   k_q, n_q;
	logic signed [SUM_W-1:0] sx_q, sy_q;
	logic [QSUM_W-1:0]  qx_q, qy_q;
	logic [SS_W-1:0]    nqx_q, nqy_q, ssx_q;
	logic signed [SS_W-1:0] sxx_q, syy_q, ssy_q;
	logic [SS_W-1:0]    rrem_q;
	logic [RSH-1:0]     rbits_q;
	logic [RATIO_W-1:0] rquo_q;
	logic [RATIO_W-1:0] sqv_q, sqr_q, sqb_q;
	logic [SCALE_W-1:0] scale_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [PULSE_W-1:0] res_pulse_q;
	logic               res_valid_q;
	logic [SCALE_W-1:0] res_scale_q;

	logic [ENTRY_W-1:0] mem [SLOTS];
	logic [ENTRY_W-1:0] mem_rd_q;

	// combinational helpers
	logic [ACC_W-1:0]   mul_a [3];
	logic [ACC_W-1:0]   mul_b [3];
	logic [ACC_W-1:0]   sum_b [3];
	logic [RUN_W-1:0]   seed_lvl [3];
	logic [RUN_W-1:0]   run_new [3];
	logic [WEIGHT_W:0]  wb;
	logic [DREM_W-1:0]  drem_d [3];
	logic [NORM_W-1:0]  dquo_d [3];
	logic [LEVEL_W-1:0] mem_lvl [3];
	logic signed [XY_W-1:0] nrm_s [3];
	logic signed [XY_W-1:0] x_c, y2_c;
	logic signed [SQ_W-1:0] sqx_c, sqy_c;
	logic [SS_W-1:0]    nqx_c, nqy_c;
	logic signed [SS_W-1:0] sxx_c, syy_c, dx_c;
	logic [SS_W:0]      r2_c, rden_c;
	logic [RATIO_W-1:0] sqt_c;
	logic signed [PROD_W-1:0] prod_c;
	logic signed [DIFF_W-1:0] diff_c, p_c;
	logic signed [PULSE_W-1:0] p_sat;
	logic [SLOT_W-1:0]  rd_addr;
	logic               seed;

	assign seed = (stored_q == '0);
	assign wb   = (WEIGHT_W + 1)'(1 << WEIGHT_W) - {1'b0, cfg.smoothing_weight};

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			seed_lvl[c] = {lvl_q[c], 8'b0};
			mul_a[c]    = cfg.smoothing_weight * run_q[c];
			mul_b[c]    = wb * seed_lvl[c];
			sum_b[c]    = acc_q[c] + mul_b[c];
			run_new[c]  = seed ? seed_lvl[c] : sum_b[c][RUN_W+15:16];
			if (run_new[c] == '0)
				run_new[c] = ONE_Q16;
			mem_lvl[c]  = mem_rd_q[c*LEVEL_W +: LEVEL_W];
		end
	end

	// restoring division of level<<24 by the running mean, a few bits a cycle
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			drem_d[c] = drem_q[c];
			dquo_d[c] = dquo_q[c];
			for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
				drem_d[c] = {drem_d[c][DREM_W-2:0], 1'b0};
				dquo_d[c] = {dquo_d[c][NORM_W-2:0], 1'b0};
				if (drem_d[c] >= {1'b0, run_q[c]}) begin
					drem_d[c]    = drem_d[c] - {1'b0, run_q[c]};
					dquo_d[c][0] = 1'b1;
				end
			end
			nrm_s[c] = $signed({{(XY_W - NORM_W){1'b0}}, dsat_q[c] ? NORM_MAX : dquo_q[c]});
		end
		x_c  = (nrm_s[0] <<< 1) + nrm_s[0] - (nrm_s[1] <<< 1);
		y2_c = (nrm_s[0] <<< 1) + nrm_s[0] + (nrm_s[1] <<< 1) - (nrm_s[2] <<< 1) - nrm_s[2];
	end

	assign sqx_c = ex_q * ex_q;
	assign sqy_c = ey_q * ey_q;
	assign nqx_c = n_q * qx_q;
	assign nqy_c = n_q * qy_q;
	assign sxx_c = sx_q * sx_q;
	assign syy_c = sy_q * sy_q;
	assign dx_c  = $signed(nqx_q) - sxx_q;

	assign rden_c = {1'b0, ssy_q};
	assign r2_c   = {rrem_q, rbits_q[RSH-1]};
	assign sqt_c  = sqr_q + sqb_q;

	assign prod_c = $signed({1'b0, scale_q}) * y2_q;
	assign diff_c = $signed({x_q, {PULSE_SH{1'b0}}}) - prod_q;
	assign p_c    = diff_c >>> PULSE_SH;

	always_comb begin
		if (p_c > P_MAX)
			p_sat = PULSE_W'(P_MAX);
		else if (p_c < P_MIN)
			p_sat = PULSE_W'(P_MIN);
		else
			p_sat = p_c[PULSE_W-1:0];
	end

	assign rd_addr = slot_q - SLOT_W'(1) - SLOT_W'(k_q);

	assign stat.action    = action_q;
	assign stat.warm_ok   = (warmup_q >= WARM_W'(WARMUP_FRAMES - 1));
	assign stat.hist_ok   = (stored_q >= HIST_W'(MIN_HISTORY));
	assign stat.win_last  = (k_q == n_q - WIN_W'(1));
	assign stat.ssy_pos   = (ssy_q > 0);
	assign stat.ratio_sat = ({{RSH{1'b0}}, ssx_q} >= {ssy_q, {RSH{1'b0}}});

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warmup_q <= '0;
			stored_q <= '0;
			slot_q   <= '0;
			for (int c = 0; c < 3; c++)
				run_q[c] <= '0;
		end else begin
			case (op)
				OP_CLEAR: begin
					warmup_q <= '0;
					stored_q <= '0;
					slot_q   <= '0;
					for (int c = 0; c < 3; c++)
						run_q[c] <= '0;
				end
				OP_WARM: begin
					if (warmup_q != WARM_MAX)
						warmup_q <= warmup_q + 1'b1;
				end
				OP_SMOOTH_B: begin
					for (int c = 0; c < 3; c++)
						run_q[c] <= run_new[c];
				end
				OP_PULSE_OUT: begin
					slot_q <= slot_q + 1'b1;
					if ({1'b0, stored_q} + 1'b1 <= {1'b0, cfg.history_limit})
						stored_q <= stored_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (op)
			OP_LATCH: begin
				action_q <= in_action;
				lvl_q[0] <= in_red;
				lvl_q[1] <= in_green;
				lvl_q[2] <= in_blue;
			end
			OP_CLEAR, OP_ZERO, OP_WARM: begin
				res_pulse_q <= '0;
				res_valid_q <= 1'b0;
				res_scale_q <= '0;
			end
			OP_SMOOTH_A: begin
				for (int c = 0; c < 3; c++)
					acc_q[c] <= mul_a[c] + ACC_W'(32768);
			end
			OP_DIV_CUR: begin
				for (int c = 0; c < 3; c++) begin
					drem_q[c] <= DREM_W'({lvl_q[c], 4'b0});
					dquo_q[c] <= '0;
					dsat_q[c] <= ({4'b0, lvl_q[c], 4'b0} >= run_q[c]);
				end
			end
			OP_DIV_MEM: begin
				for (int c = 0; c < 3; c++) begin
					drem_q[c] <= DREM_W'({mem_lvl[c], 4'b0});
					dquo_q[c] <= '0;
					dsat_q[c] <= ({4'b0, mem_lvl[c], 4'b0} >= run_q[c]);
				end
			end
			OP_DIV_STEP: begin
				for (int c = 0; c < 3; c++) begin
					drem_q[c] <= drem_d[c];
					dquo_q[c] <= dquo_d[c];
				end
			end
			OP_CUR_XY: begin
				x_q     <= x_c;
				y2_q    <= y2_c;
				scale_q <= SCALE_W'(ONE_Q16);
			end
			OP_WIN_INIT: begin
				k_q  <= '0;
				n_q  <= (stored_q < HIST_W'(WINDOW_FRAMES)) ? WIN_W'(stored_q)
				                                            : WIN_W'(WINDOW_FRAMES);
				sx_q <= '0;
				sy_q <= '0;
				qx_q <= '0;
				qy_q <= '0;
			end
			OP_MEM_RD: mem_rd_q <= mem[rd_addr];
			OP_WIN_XY: begin
				ex_q <= x_c;
				ey_q <= y2_c;
			end
			OP_WIN_ACC: begin
				sx_q <= sx_q + SUM_W'(ex_q);
				sy_q <= sy_q + SUM_W'(ey_q);
				qx_q <= qx_q + QSUM_W'($unsigned(sqx_c));
				qy_q <= qy_q + QSUM_W'($unsigned(sqy_c));
				k_q  <= k_q + 1'b1;
			end
			OP_SS_MUL: begin
				nqx_q <= nqx_c;
				nqy_q <= nqy_c;
				sxx_q <= sxx_c;
				syy_q <= syy_c;
			end
			OP_SS_SUB: begin
				ssx_q <= (dx_c < 0) ? '0 : $unsigned(dx_c);
				ssy_q <= $signed(nqy_q) - syy_q;
			end
			OP_SCALE_SAT: scale_q <= SCALE_MAX;
			OP_RATIO_INIT: begin
				rrem_q  <= ssx_q >> RSH;
				rbits_q <= ssx_q[RSH-1:0];
				rquo_q  <= '0;
			end
			OP_RATIO_STEP: begin
				rbits_q <= {rbits_q[RSH-2:0], 1'b0};
				if (r2_c >= rden_c) begin
					rrem_q <= SS_W'(r2_c - rden_c);
					rquo_q <= {rquo_q[RATIO_W-2:0], 1'b1};
				end else begin
					rrem_q <= r2_c[SS_W-1:0];
					rquo_q <= {rquo_q[RATIO_W-2:0], 1'b0};
				end
			end
			OP_SQRT_INIT: begin
				sqv_q <= rquo_q;
				sqr_q <= '0;
				sqb_q <= SQB_INIT;
			end
			OP_SQRT_STEP: begin
				if (sqv_q >= sqt_c) begin
					sqv_q <= sqv_q - sqt_c;
					sqr_q <= (sqr_q >> 1) + sqb_q;
				end else begin
					sqr_q <= sqr_q >> 1;
				end
				sqb_q <= sqb_q >> 2;
			end
			OP_SQRT_DONE: scale_q <= sqr_q[SCALE_W-1:0];
			OP_PULSE_MUL: prod_q <= prod_c;
			OP_PULSE_OUT: begin
				res_pulse_q <= p_sat;
				res_valid_q <= 1'b1;
				res_scale_q <= scale_q;
			end
			OP_OUT_LOAD: begin
				pulse_value <= res_pulse_q;
				pulse_valid <= res_valid_q;
				scale_used  <= res_scale_q;
			end
			default: ;
		endcase
	end

	// level history
	always_ff @(posedge clk) begin
		if (op == OP_PULSE_OUT)
			mem[slot_q] <= {lvl_q[2], lvl_q[1], lvl_q[0]};
	end

endmodule
`default_nettype wire

[hdl/chrom_pulse_extractor.sv]
// CHROM pulse extractor top level.
// Usage:
//   in_ch carries one word per video frame: action (0 frame with region means,
//   1 empty frame, 2 clear all state, 3 treated as empty) and the Q8.8 red,
//   green and blue means. out_ch returns exactly one word per input word:
//   the Q16.16 pulse sample, its valid flag and the Q8.16 scale applied.
//   The APB port holds history_limit (0x0) and smoothing_weight (0x4);
//   write them only while the block is idle.
// Flow:
//   One frame is in work at a time. Empty, clear and warmup words go
//   straight to the output register. A computed frame with fewer than 30
//   stored frames skips the window. Otherwise the window walk dominates:
//   per window entry (up to 60) a memory read, radix-16 norm dividers,
//   square and accumulate, then, unless the Y spread is zero or the ratio
//   saturates, ratio division and square root.
// Reset and stall:
//   Reset clears the counters, running means and the output valid flag;
//   the level history is only read where written. A finished word waits in
//   the output register; the next input word is taken meanwhile and held
//   until that register frees.
`timescale 1ns / 1ps
`default_nettype none
module chrom_pulse_extractor import cpe_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	cpe_in_if.sink                 in_ch,
	cpe_out_if.source              out_ch,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready
);

	cpe_cfg_t  cfg;
	cpe_stat_t stat;
	cpe_op_t   op;

	cpe_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cpe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.op        (op)
	);

	cpe_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.cfg         (cfg),
		.in_action   (in_ch.action),
		.in_red      (in_ch.red_level),
		.in_green    (in_ch.green_level),
		.in_blue     (in_ch.blue_level),
		.stat        (stat),
		.pulse_value (out_ch.pulse_value),
		.pulse_valid (out_ch.pulse_valid),
		.scale_used  (out_ch.scale_used)
	);

endmodule
`default_nettype wire

[test/chrom_pulse_extractor_tb.sv]
// Self-checking testbench for the CHROM pulse extractor: random frames against a built-in predictor.
`timescale 1ns / 1ps
`default_nettype none
module chrom_pulse_extractor_tb;
	import cpe_pkg::*;

	typedef struct packed {
		logic [1:0]         action;
		logic [LEVEL_W-1:0] red;
		logic [LEVEL_W-1:0] green;
		logic [LEVEL_W-1:0] blue;
	} frame_word_t;

	typedef struct packed {
		logic signed [PULSE_W-1:0] pulse;
		logic                      pvalid;
		logic [SCALE_W-1:0]        scale;
	} pulse_word_t;

	localparam longint CYCLE_LIMIT = 4000000;
	localparam int     BUF_W       = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	cpe_in_if  in_ch ();
	cpe_out_if out_ch ();

	chrom_pulse_extractor u_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// predictor state and registers
	logic [HIST_W-1:0]   lim_q;
	logic [WEIGHT_W-1:0] wgt_q;
	logic [WARM_W-1:0]   warm_q;
	logic [HIST_W-1:0]   kept_q;
	logic [RUN_W-1:0]    mean_r, mean_g, mean_b;
	logic [ENTRY_W-1:0]  level_hist [SLOTS];
	logic [SLOT_W-1:0]   slot_q;

	// pending frames and expected words, ring buffers with wrapping indexes
	frame_word_t send_buf [1 << BUF_W];
	pulse_word_t due_buf [1 << BUF_W];
	logic [BUF_W-1:0] send_wr = '0, send_rd = '0;
	logic [BUF_W-1:0] due_wr = '0, due_rd = '0;
	int send_idle = 0, recv_idle = 0;
	int errors = 0, words_in = 0, words_out = 0, computed = 0, scaled = 0;
	longint cycles = 0;
	logic in_fired = 1'b0;

	task automatic report(input string what, input longint got, input longint want);
		$display("ERROR word %0d: %s got %0h expected %0h", words_out, what, got, want);
		errors++;
	endtask

	function automatic void wipe_state();
		warm_q = '0;
		kept_q = '0;
		mean_r = '0;
		mean_g = '0;
		mean_b = '0;
		slot_q = '0;
	endfunction

	function automatic logic [RUN_W-1:0] smoothed(logic [RUN_W-1:0] run,
		logic [LEVEL_W-1:0] lv, logic seed);
		longint unsigned s, w, v;
		s = longint'(lv) << 8;
		w = wgt_q;
		if (seed)
			return RUN_W'(s);
		v = (w * run + (65536 - w) * s + 32768) >> 16;
		return RUN_W'(v);
	endfunction

	function automatic longint normed(logic [LEVEL_W-1:0] lv, logic [RUN_W-1:0] run);
		longint unsigned q;
		q = (longint'(lv) << 24) / run;
		if (q > NORM_MAX)
			q = NORM_MAX;
		return longint'(q);
	endfunction

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned r, t;
		r = 0;
		for (int i = 31; i >= 0; i--) begin
			t = r | (64'd1 << i);
			if (t * t <= v)
				r = t;
		end
		return r;
	endfunction

	function automatic pulse_word_t chrom_step(frame_word_t f);
		pulse_word_t o;
		longint x, y2, ex, ey, sx, sy, qx, qy, ssx, ssy, p, nr, ng, nb;
		longint unsigned scl, n;
		logic [127:0] quot;
		logic seed;
		logic [ENTRY_W-1:0] e;
		o = '0;
		if (f.action == ACT_CLEAR) begin
			wipe_state();
			return o;
		end
		if (f.action != ACT_FRAME)
			return o;
		if (warm_q != WARM_MAX)
			warm_q++;
		if (warm_q < WARMUP_FRAMES)
			return o;
		seed = (kept_q == 0);
		mean_r = smoothed(mean_r, f.red, seed);
		mean_g = smoothed(mean_g, f.green, seed);
		mean_b = smoothed(mean_b, f.blue, seed);
		if (mean_r == 0) mean_r = ONE_Q16;
		if (mean_g == 0) mean_g = ONE_Q16;
		if (mean_b == 0) mean_b = ONE_Q16;
		nr = normed(f.red, mean_r);
		ng = normed(f.green, mean_g);
		nb = normed(f.blue, mean_b);
		x = 3 * nr - 2 * ng;
		y2 = 3 * nr + 2 * ng - 3 * nb;
		scl = ONE_Q16;
		if (kept_q >= MIN_HISTORY) begin
			sx = 0; sy = 0; qx = 0; qy = 0;
			n = kept_q < WINDOW_FRAMES ? kept_q : WINDOW_FRAMES;
			for (int k = 0; k < n; k++) begin
				e = level_hist[SLOT_W'(slot_q - 1 - k)];
				nr = normed(e[15:0], mean_r);
				ng = normed(e[31:16], mean_g);
				nb = normed(e[47:32], mean_b);
				ex = 3 * nr - 2 * ng;
				ey = 3 * nr + 2 * ng - 3 * nb;
				sx += ex; sy += ey;
				qx += ex * ex; qy += ey * ey;
			end
			ssx = longint'(n) * qx - sx * sx;
			ssy = longint'(n) * qy - sy * sy;
			if (ssx < 0)
				ssx = 0;
			if (ssy > 0) begin
				quot = (128'(ssx) << RATIO_FRAC) / 128'(ssy);
				if (quot > (128'd1 << RATIO_W))
					quot = 128'd1 << RATIO_W;
				scl = root_floor(quot[63:0]);
				if (scl > SCALE_MAX)
					scl = SCALE_MAX;
				scaled++;
			end
		end
		p = (x * 131072 - longint'(scl) * y2) >>> PULSE_SH;
		if (p > 64'sd2147483647)
			p = 64'sd2147483647;
		if (p < -64'sd2147483648)
			p = -64'sd2147483648;
		o.pulse = PULSE_W'(p);
		o.pvalid = 1'b1;
		o.scale = SCALE_W'(scl);
		level_hist[slot_q] = {f.blue, f.green, f.red};
		slot_q++;
		if (32'(kept_q) + 1 <= 32'(lim_q))
			kept_q++;
		computed++;
		return o;
	endfunction

	// input side: sample handshake at posedge, drive at negedge
	always @(posedge clk) begin
		cycles++;
		in_fired = in_ch.valid && in_ch.ready;
		if (in_fired) begin
			due_buf[due_wr] = chrom_step({in_ch.action, in_ch.red_level,
				in_ch.green_level, in_ch.blue_level});
			due_wr = due_wr + 1'b1;
			words_in++;
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("chrom_pulse_extractor: mismatch");
			$finish;
		end
	end

	always @(negedge clk) begin
		frame_word_t f;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (!in_ch.valid || in_fired) begin
			if (send_wr != send_rd && $urandom_range(99) >= send_idle) begin
				f = send_buf[send_rd];
				send_rd = send_rd + 1'b1;
				in_ch.valid <= 1'b1;
				in_ch.action <= f.action;
				in_ch.red_level <= f.red;
				in_ch.green_level <= f.green;
				in_ch.blue_level <= f.blue;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		out_ch.ready <= arst_n && ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		pulse_word_t w;
		if (out_ch.valid && out_ch.ready) begin
			if (due_wr == due_rd) begin
				report("unexpected word, pulse", out_ch.pulse_value, 0);
			end else begin
				w = due_buf[due_rd];
				due_rd = due_rd + 1'b1;
				if (out_ch.pulse_value !== w.pulse)
					report("pulse_value", out_ch.pulse_value, w.pulse);
				if (out_ch.pulse_valid !== w.pvalid)
					report("pulse_valid", out_ch.pulse_valid, w.pvalid);
				if (out_ch.scale_used !== w.scale)
					report("scale_used", out_ch.scale_used, w.scale);
			end
			words_out++;
		end
	end

	task automatic drain();
		while (send_wr != send_rd || in_ch.valid || due_wr != due_rd)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic apb_write(input logic addr_sel, input logic [DATA_W-1:0] v);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= ADDR_W'(addr_sel) << 2;
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (addr_sel == REG_HISTORY)
			lim_q = HIST_W'(v);
		else
			wgt_q = WEIGHT_W'(v);
	endtask

	task automatic add_word(input logic [1:0] a, input logic [15:0] r,
		input logic [15:0] g, input logic [15:0] b);
		send_buf[send_wr] = {a, r, g, b};
		send_wr = send_wr + 1'b1;
	endtask

	function automatic logic [15:0] jitter(int base, int span);
		int v;
		v = base + $urandom_range(2 * span) - span;
		if (v < 0) v = 0;
		if (v > 65535) v = 65535;
		return 16'(v);
	endfunction

	// mostly well-formed frame runs around a drifting color, some noise
	task automatic add_random(input int count);
		int br, bg, bb, span, pick;
		br = $urandom_range(65535); bg = $urandom_range(65535); bb = $urandom_range(65535);
		span = $urandom_range(1, 2000);
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 1)
				add_word(ACT_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
			else if (pick < 5)
				add_word(ACT_EMPTY, 16'($urandom), 16'($urandom), 16'($urandom));
			else if (pick < 7)
				add_word(2'd3, 16'($urandom), 16'($urandom), 16'($urandom));
			else if (pick < 17)
				add_word(ACT_FRAME, 16'($urandom), 16'($urandom), 16'($urandom));
			else
				add_word(ACT_FRAME, jitter(br, span), jitter(bg, span), jitter(bb, span));
			if ($urandom_range(49) == 0) begin
				br = $urandom_range(65535); bg = $urandom_range(65535);
				bb = $urandom_range(65535); span = $urandom_range(1, 2000);
			end
		end
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.action = ACT_EMPTY;
		in_ch.red_level = '0;
		in_ch.green_level = '0;
		in_ch.blue_level = '0;
		out_ch.ready = 1'b0;
		lim_q = HIST_RESET;
		wgt_q = WEIGHT_RESET;
		wipe_state();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle = 18; recv_idle = 58;
		apb_write(REG_HISTORY, 32'd1800);
		apb_write(REG_WEIGHT, 32'd62259);
		add_word(ACT_EMPTY, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		add_word(2'd3, 16'h0000, 16'h0000, 16'h0000);
		add_word(ACT_CLEAR, 16'hFFFF, 16'h0000, 16'hFFFF);
		for (int i = 0; i < 14; i++)
			add_word(ACT_FRAME, i[0] ? 16'hFFFF : 16'h0, 16'h1234, 16'hFFFF);
		// first stored frame is all zero: running means fall back to 1.0
		add_word(ACT_FRAME, 16'h0000, 16'h0000, 16'h0000);
		add_word(ACT_FRAME, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		add_word(ACT_FRAME, 16'hFFFF, 16'h0000, 16'hFFFF);
		add_word(ACT_FRAME, 16'h0000, 16'hFFFF, 16'h0000);
		add_word(ACT_EMPTY, 16'h0, 16'h0, 16'h0);
		add_random(90);
		drain();
		// sender holds off until every word has come back
		add_random(90);
		drain();

		send_idle = 58; recv_idle = 18;
		apb_write(REG_HISTORY, 32'd35);
		apb_write(REG_WEIGHT, 32'd0);
		add_random(180);
		drain();

		send_idle = 0; recv_idle = 0;
		apb_write(REG_HISTORY, 32'd4095);
		apb_write(REG_WEIGHT, 32'd65535);
		add_random(120);
		drain();
		apb_write(REG_HISTORY, 32'd1);
		apb_write(REG_WEIGHT, 32'd32768);
		add_random(50);
		drain();

		$display("%0d words in, %0d out, %0d pulses computed, %0d with window scale",
			words_in, words_out, computed, scaled);
		$display("history limits 1800/35/4095/1, weights 62259/0/65535/32768");
		if (errors == 0 && due_wr == due_rd)
			$display("chrom_pulse_extractor: match");
		else
			$display("chrom_pulse_extractor: mismatch");
		$finish;
	end

endmodule
`default_nettype wire

[filelist.f]
hdl/cpe_pkg.sv
hdl/cpe_in_if.sv
hdl/cpe_out_if.sv
hdl/cpe_regs.sv
hdl/cpe_ctrl.sv
hdl/cpe_dp.sv
hdl/chrom_pulse_extractor.sv
test/chrom_pulse_extractor_tb.sv
